// ----- rtl/assert_macros.svh -----
// Assertion macros used by the verification checker of the color converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent true implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent true implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/hsv_pkg.sv -----
// Package with constants and stage payload types of the HSV to RGB converter.
`default_nettype none

package hsv_pkg;

    localparam int HueFullTurn = 5760;
    localparam int HueSector   = 960;
    localparam int QOne        = 32768;
    localparam int ChannelMax  = 255;

    localparam logic [24:0] LevelFull = 25'(QOne * HueSector);

    typedef enum logic [2:0] {
        SEC_R_TO_Y,
        SEC_Y_TO_G,
        SEC_G_TO_C,
        SEC_C_TO_B,
        SEC_B_TO_M,
        SEC_M_TO_R
    } sector_t;

    typedef struct packed {
        logic [15:0] sat;
        logic [15:0] val;
        sector_t     sector;
        logic [9:0]  frac;
    } sect_word_t;

    typedef struct packed {
        logic [15:0] val;
        sector_t     sector;
        logic [24:0] lvl_p;
        logic [24:0] lvl_q;
        logic [24:0] lvl_t;
    } level_word_t;

    typedef struct packed {
        logic [39:0] num_r;
        logic [39:0] num_g;
        logic [39:0] num_b;
    } mix_word_t;

endpackage

`default_nettype wire

// ----- rtl/hsv_to_rgb_converter_top.sv -----
// Top level of the HSV to RGB converter: a four-stage pipeline with stream ports.
// An accepted input word passes the sector, level, mix and round registers to a valid output word.
// Throughput is one word per cycle while the output is not stalled; each stage register advances on its own ready.
// A stalled output holds its word while empty earlier stages still take input.
// Synchronous active-low reset clears the valid bit of every stage; data is not reset.
`default_nettype none

module hsv_to_rgb_converter_top import hsv_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // hue[12:0], saturation[28:13], brightness[44:29]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // red[7:0], green[15:8], blue[23:16]
);

    logic        sect_valid;
    logic        sect_ready;
    sect_word_t  sect_word;
    logic        lvl_valid;
    logic        lvl_ready;
    level_word_t lvl_word;
    logic        mix_valid;
    logic        mix_ready;
    mix_word_t   mix_word;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;

    hsv_sector u_sector (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_hue    (s_tdata[12:0]),
        .in_sat    (s_tdata[28:13]),
        .in_val    (s_tdata[44:29]),
        .out_valid (sect_valid),
        .out_ready (sect_ready),
        .out_word  (sect_word)
    );

    hsv_level u_level (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sect_valid),
        .in_ready  (sect_ready),
        .in_word   (sect_word),
        .out_valid (lvl_valid),
        .out_ready (lvl_ready),
        .out_word  (lvl_word)
    );

    hsv_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (lvl_valid),
        .in_ready  (lvl_ready),
        .in_word   (lvl_word),
        .out_valid (mix_valid),
        .out_ready (mix_ready),
        .out_word  (mix_word)
    );

    hsv_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mix_valid),
        .in_ready  (mix_ready),
        .in_word   (mix_word),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_red   (red),
        .out_green (green),
        .out_blue  (blue)
    );

    assign m_tdata = {blue, green, red};

endmodule

`default_nettype wire

// ----- rtl/hsv_sector.sv -----
// First stage: clamps the inputs, wraps the hue and splits it into sector and fraction.
`default_nettype none

module hsv_sector import hsv_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [12:0] in_hue,
    input  wire logic [15:0] in_sat,
    input  wire logic [15:0] in_val,
    output logic             out_valid,
    input  wire logic        out_ready,
    output sect_word_t       out_word
);

    logic        valid_reg;
    sect_word_t  word_reg;
    sect_word_t  word_next;
    logic [12:0] hue_wrap;
    logic [12:0] hue_base;

    always_comb begin
        hue_wrap = (in_hue >= 13'(HueFullTurn)) ? in_hue - 13'(HueFullTurn) : in_hue;
        if (hue_wrap < 13'(HueSector)) begin
            word_next.sector = SEC_R_TO_Y;
            hue_base = 13'd0;
        end else if (hue_wrap < 13'(2 * HueSector)) begin
            word_next.sector = SEC_Y_TO_G;
            hue_base = 13'(HueSector);
        end else if (hue_wrap < 13'(3 * HueSector)) begin
            word_next.sector = SEC_G_TO_C;
            hue_base = 13'(2 * HueSector);
        end else if (hue_wrap < 13'(4 * HueSector)) begin
            word_next.sector = SEC_C_TO_B;
            hue_base = 13'(3 * HueSector);
        end else if (hue_wrap < 13'(5 * HueSector)) begin
            word_next.sector = SEC_B_TO_M;
            hue_base = 13'(4 * HueSector);
        end else begin
            word_next.sector = SEC_M_TO_R;
            hue_base = 13'(5 * HueSector);
        end
        word_next.frac = 10'(hue_wrap - hue_base);
        word_next.sat  = (in_sat > 16'(QOne)) ? 16'(QOne) : in_sat;
        word_next.val  = (in_val > 16'(QOne)) ? 16'(QOne) : in_val;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

// ----- rtl/hsv_level.sv -----
// Second stage: forms the p, q and t levels from saturation and fraction.
`default_nettype none

module hsv_level import hsv_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  sect_word_t in_word,
    output logic       out_valid,
    input  wire logic  out_ready,
    output level_word_t out_word
);

    logic        valid_reg;
    level_word_t word_reg;
    level_word_t word_next;
    logic [25:0] prod_q;
    logic [25:0] prod_t;
    logic [25:0] prod_p;
    logic [9:0]  frac_inv;
    logic [15:0] sat_inv;

    always_comb begin
        frac_inv = 10'(HueSector) - in_word.frac;
        sat_inv  = 16'(QOne) - in_word.sat;
        prod_q   = {10'b0, in_word.sat} * {16'b0, in_word.frac};
        prod_t   = {10'b0, in_word.sat} * {16'b0, frac_inv};
        prod_p   = {10'b0, sat_inv} * 26'(HueSector);
        word_next.val    = in_word.val;
        word_next.sector = in_word.sector;
        word_next.lvl_p  = prod_p[24:0];
        word_next.lvl_q  = LevelFull - prod_q[24:0];
        word_next.lvl_t  = LevelFull - prod_t[24:0];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

// ----- rtl/hsv_mix.sv -----
// Third stage: places the levels by sector and scales each by the value.
`default_nettype none

module hsv_mix import hsv_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  level_word_t in_word,
    output logic        out_valid,
    input  wire logic   out_ready,
    output mix_word_t   out_word
);

    logic        valid_reg;
    mix_word_t   word_reg;
    mix_word_t   word_next;
    logic [24:0] lvl_r;
    logic [24:0] lvl_g;
    logic [24:0] lvl_b;
    logic [40:0] prod_r;
    logic [40:0] prod_g;
    logic [40:0] prod_b;

    always_comb begin
        case (in_word.sector)
            SEC_R_TO_Y: begin
                lvl_r = LevelFull;     lvl_g = in_word.lvl_t; lvl_b = in_word.lvl_p;
            end
            SEC_Y_TO_G: begin
                lvl_r = in_word.lvl_q; lvl_g = LevelFull;     lvl_b = in_word.lvl_p;
            end
            SEC_G_TO_C: begin
                lvl_r = in_word.lvl_p; lvl_g = LevelFull;     lvl_b = in_word.lvl_t;
            end
            SEC_C_TO_B: begin
                lvl_r = in_word.lvl_p; lvl_g = in_word.lvl_q; lvl_b = LevelFull;
            end
            SEC_B_TO_M: begin
                lvl_r = in_word.lvl_t; lvl_g = in_word.lvl_p; lvl_b = LevelFull;
            end
            default: begin
                lvl_r = LevelFull;     lvl_g = in_word.lvl_p; lvl_b = in_word.lvl_q;
            end
        endcase
        prod_r = {25'b0, in_word.val} * {16'b0, lvl_r};
        prod_g = {25'b0, in_word.val} * {16'b0, lvl_g};
        prod_b = {25'b0, in_word.val} * {16'b0, lvl_b};
        word_next.num_r = prod_r[39:0];
        word_next.num_g = prod_g[39:0];
        word_next.num_b = prod_b[39:0];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

// ----- rtl/hsv_round.sv -----
// Fourth stage: scales each channel to eight bits with rounding and holds the output word.
`default_nettype none

module hsv_round import hsv_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  mix_word_t  in_word,
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue
);

    logic       valid_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic [7:0] red_next;
    logic [7:0] green_next;
    logic [7:0] blue_next;

    // The level scale is 960 * 2^30; times 255 over that scale reduces to 17 / 2^36.
    function automatic logic [7:0] to_byte(input logic [39:0] num);
        logic [44:0] acc;
        acc = {1'b0, num, 4'b0} + {5'b0, num} + (45'd1 << 35);
        if (acc[44:36] > 9'(ChannelMax)) begin
            return 8'(ChannelMax);
        end
        return acc[43:36];
    endfunction

    always_comb begin
        red_next   = to_byte(in_word.num_r);
        green_next = to_byte(in_word.num_g);
        blue_next  = to_byte(in_word.num_b);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;

endmodule

`default_nettype wire

// ----- rtl/hsv_checker.sv -----
// Port-level checker for the HSV to RGB converter, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module hsv_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    logic in_word_taken;

    assign in_word_taken = s_tvalid && s_tready;

    // A stalled output word stays valid and unchanged.
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // An empty output stage means every stage can take a word.
    `ASSERT_IMPLY(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready)

    // If the output drains, each accepted word turns into a valid output.
    `ASSERT_IMPLY(a_latency, aclk, aresetn,
        $past(in_word_taken, 4) && $past(m_tready, 1) && $past(m_tready, 2) &&
        $past(m_tready, 3) && $past(aresetn, 1) && $past(aresetn, 2) &&
        $past(aresetn, 3) && $past(aresetn, 4), m_tvalid)

endmodule

bind hsv_to_rgb_converter_top hsv_checker u_hsv_checker (.*);

`default_nettype wire

// ----- bench/tb_hsv_to_rgb_converter_top.sv -----
// Self-checking testbench of the HSV to RGB converter with bursty stream traffic.
`default_nettype none

module tb_hsv_to_rgb_converter_top import hsv_pkg::*;;

    typedef struct packed {
        logic [2:0]  pad;
        logic [15:0] brightness;
        logic [15:0] saturation;
        logic [12:0] hue;
    } hsv_word_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_word_t;

    localparam longint unsigned QONE_L   = QOne;
    localparam longint unsigned SECTOR_L = HueSector;
    localparam longint unsigned LEVEL_DEN = QONE_L * QONE_L * SECTOR_L;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    rgb_word_t rgb_pending[$];
    int words_sent;
    int words_checked;
    int mismatch_count;
    int tx_burst_left;
    int tx_gap_max;
    int tx_burst_max;
    int rx_stall_pct;
    int rx_hold_req;

    hsv_to_rgb_converter_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    function automatic logic [7:0] level_to_channel(longint unsigned num);
        longint unsigned r;
        r = (num * 255 + LEVEL_DEN / 2) / LEVEL_DEN;
        if (r > 255) begin
            r = 255;
        end
        return r[7:0];
    endfunction

    function automatic rgb_word_t predict_rgb(hsv_word_t w);
        longint unsigned h, s, v, f, vn, pn, qn, tn, rn, gn, bn;
        sector_t sec;
        rgb_word_t c;
        h = w.hue;
        s = w.saturation;
        v = w.brightness;
        if (s > QONE_L) begin
            s = QONE_L;
        end
        if (v > QONE_L) begin
            v = QONE_L;
        end
        if (h >= HueFullTurn) begin
            h = h - HueFullTurn;
        end
        vn = v * QONE_L * SECTOR_L;
        if (s == 0) begin
            rn = vn;
            gn = vn;
            bn = vn;
        end else begin
            sec = sector_t'(3'(h / SECTOR_L));
            f = h % SECTOR_L;
            pn = v * (QONE_L - s) * SECTOR_L;
            qn = v * (QONE_L * SECTOR_L - s * f);
            tn = v * (QONE_L * SECTOR_L - s * (SECTOR_L - f));
            case (sec)
                SEC_R_TO_Y: begin rn = vn; gn = tn; bn = pn; end
                SEC_Y_TO_G: begin rn = qn; gn = vn; bn = pn; end
                SEC_G_TO_C: begin rn = pn; gn = vn; bn = tn; end
                SEC_C_TO_B: begin rn = pn; gn = qn; bn = vn; end
                SEC_B_TO_M: begin rn = tn; gn = pn; bn = vn; end
                default: begin rn = vn; gn = pn; bn = qn; end
            endcase
        end
        c.red = level_to_channel(rn);
        c.green = level_to_channel(gn);
        c.blue = level_to_channel(bn);
        return c;
    endfunction

    function automatic logic [15:0] random_q15();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            return 16'd0;
        end else if (pick < 14) begin
            return 16'(QOne);
        end else if (pick < 26) begin
            return 16'($urandom_range(65535));
        end
        return 16'($urandom_range(QOne));
    endfunction

    function automatic hsv_word_t random_hsv();
        hsv_word_t w;
        w = '0;
        if ($urandom_range(99) < 15) begin
            w.hue = 13'($urandom_range(8191));
        end else begin
            w.hue = 13'($urandom_range(HueFullTurn));
        end
        w.saturation = random_q15();
        w.brightness = random_q15();
        return w;
    endfunction

    task automatic send_hsv(input logic [12:0] hue, input logic [15:0] sat,
                            input logic [15:0] val);
        hsv_word_t w;
        int gap;
        w = '0;
        w.hue = hue;
        w.saturation = sat;
        w.brightness = val;
        if (tx_burst_left == 0) begin
            gap = $urandom_range(tx_gap_max);
            tx_burst_left = $urandom_range(1, tx_burst_max);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        rgb_pending.push_back(predict_rgb(w));
        words_sent++;
        tx_burst_left--;
    endtask

    task automatic send_random(input int count);
        hsv_word_t w;
        repeat (count) begin
            w = random_hsv();
            send_hsv(w.hue, w.saturation, w.brightness);
        end
    endtask

    task automatic test_directed_corners();
        int k;
        tx_gap_max = 2;
        tx_burst_max = 4;
        rx_stall_pct = 20;
        send_hsv(13'd0, 16'd0, 16'd0);
        send_hsv(13'd0, 16'd0, 16'd32768);
        send_hsv(13'd1234, 16'd0, 16'd20000);
        send_hsv(13'd0, 16'd32768, 16'd32768);
        for (k = 1; k < 6; k++) begin
            send_hsv(13'(k * HueSector - 1), 16'd32768, 16'd32768);
            send_hsv(13'(k * HueSector), 16'd32768, 16'd32768);
        end
        send_hsv(13'd5759, 16'd32768, 16'd32768);
        send_hsv(13'd5760, 16'd32768, 16'd32768);
        send_hsv(13'd5761, 16'd30000, 16'd30000);
        send_hsv(13'd8191, 16'd65535, 16'd65535);
        send_hsv(13'd480, 16'd32769, 16'd40000);
        send_hsv(13'd3000, 16'd1, 16'd32767);
        send_hsv(13'd2500, 16'd32767, 16'd1);
        send_hsv(13'd4321, 16'd16384, 16'd0);
        send_hsv(13'd6000, 16'd0, 16'd65535);
    endtask

    task automatic test_random_bursty();
        tx_gap_max = 6;
        tx_burst_max = 10;
        rx_stall_pct = 35;
        send_random(700);
    endtask

    task automatic test_full_rate();
        tx_gap_max = 0;
        tx_burst_max = 50;
        rx_stall_pct = 0;
        send_random(400);
    endtask

    task automatic test_output_hold_off();
        tx_gap_max = 0;
        tx_burst_max = 40;
        rx_stall_pct = 0;
        rx_hold_req = 300;
        send_random(50);
        tx_gap_max = 3;
        tx_burst_max = 8;
        rx_stall_pct = 50;
        send_random(400);
    endtask

    initial begin : receiver
        int hold_left;
        int run_left;
        logic stalling;
        hold_left = 0;
        run_left = 0;
        stalling = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req > 0) begin
                hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    stalling = ($urandom_range(99) < rx_stall_pct);
                    run_left = stalling ? $urandom_range(1, 6) : $urandom_range(1, 12);
                end
                run_left--;
                m_tready <= !stalling;
            end
        end
    end

    initial begin : result_check
        rgb_word_t got;
        rgb_word_t want;
        forever begin
            @(posedge aclk);
            if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
                got = m_tdata;
                if (rgb_pending.size() == 0) begin
                    $display("%0t: unexpected output word %h", $time, got);
                    mismatch_count++;
                end else begin
                    want = rgb_pending.pop_front();
                    words_checked++;
                    if (got.red !== want.red) begin
                        $display("%0t: red expected %0d, actual %0d", $time, want.red, got.red);
                        mismatch_count++;
                    end
                    if (got.green !== want.green) begin
                        $display("%0t: green expected %0d, actual %0d", $time, want.green,
                                 got.green);
                        mismatch_count++;
                    end
                    if (got.blue !== want.blue) begin
                        $display("%0t: blue expected %0d, actual %0d", $time, want.blue,
                                 got.blue);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin : watchdog
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin : main
        words_sent = 0;
        words_checked = 0;
        mismatch_count = 0;
        tx_burst_left = 0;
        tx_gap_max = 0;
        tx_burst_max = 1;
        rx_stall_pct = 0;
        rx_hold_req = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_corners();
        test_random_bursty();
        test_full_rate();
        test_output_hold_off();
        s_tvalid <= 1'b0;
        while (rgb_pending.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        $display("Sent %0d pixel words and checked %0d results across all six hue sectors,",
                 words_sent, words_checked);
        $display("with wrap, clamping, grey, full-rate, bursty and long back-pressure phases.");
        if (mismatch_count == 0 && rgb_pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
